// ===== rtl/rthd_pkg.sv =====
package rthd_pkg;

	// Stream lengths and history lengths are always held in this many bits.
	localparam int LEN_W      = 5;
	localparam int HIST_DEPTH = 4;
	localparam int SLOT_W     = 2;
	localparam logic [LEN_W-1:0] CLAMP_LIMIT = LEN_W'(7);

	typedef enum logic [1:0] {
		MODE_PAIR  = 2'd0,
		MODE_CLOSE = 2'd1,
		MODE_END   = 2'd2,
		MODE_NONE  = 2'd3
	} mode_t;

	localparam logic [2:0] PK_OPSIZE = 3'd1;
	localparam logic [2:0] PK_ADSIZE = 3'd2;
	localparam logic [2:0] PK_REPNE  = 3'd3;
	localparam logic [2:0] PK_REP    = 3'd4;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
		logic [2:0]  prefix_kind;
		logic        is_call;
		logic        is_cond_jump;
		logic        is_jump;
		logic        is_ret;
		logic        is_bad;
		logic        has_imm8;
		logic        has_imm16;
		logic        has_imm32;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		logic       truncated;
	} res_t;

	// One request from the front part to the back part.
	typedef struct packed {
		logic             is_clear;
		logic             bank;
		logic [LEN_W-1:0] len;
		logic             trunc;
		logic [7:0]       flags;
	} cmd_t;

	// The back part reports that it no longer reads a stream bank.
	typedef struct packed {
		logic done;
		logic bank;
	} done_t;

	function automatic logic [7:0] make_flags(input item_t it);
		logic [7:0] f;
		f = 8'h00;
		unique case (it.prefix_kind)
			PK_OPSIZE: f = 8'h80;
			PK_ADSIZE: f = 8'h81;
			PK_REPNE:  f = 8'h82;
			PK_REP:    f = 8'h83;
			default: begin
				if (it.is_call)      f = f | 8'h01;
				if (it.is_cond_jump) f = f | 8'h02;
				if (it.is_jump)      f = f | 8'h04;
				if (it.is_ret)       f = f | 8'h08;
				if (it.is_bad)       f = f | 8'h10;
				if (it.has_imm8)     f = f | 8'h20;
				if (it.has_imm16)    f = f | 8'h40;
				if (it.has_imm32)    f = f | 8'h60;
			end
		endcase
		return f;
	endfunction

endpackage

// ===== rtl/rthd_queue.sv =====
module rthd_queue (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rthd_pkg::cmd_t     push_cmd,
	output logic               full,
	input  logic               pop,
	output logic               head_valid,
	output rthd_pkg::cmd_t     head_cmd
);

	rthd_pkg::cmd_t entry_q [2];
	logic           wr_ptr_q;
	logic           rd_ptr_q;
	logic [1:0]     count_q;

	assign full       = (count_q == 2'd2);
	assign head_valid = (count_q != 2'd0);
	assign head_cmd   = entry_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

endmodule

// ===== rtl/rthd_front.sv =====
module rthd_front #(
	parameter int MAX_STREAM = 16,
	parameter int CAW        = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                item_valid,
	output logic                item_ready,
	input  rthd_pkg::item_t     item,
	output logic                push,
	output rthd_pkg::cmd_t      push_cmd,
	input  logic                q_full,
	input  rthd_pkg::done_t     done,
	input  logic [CAW-1:0]      rd_addr,
	output logic [15:0]         rd_data
);

	localparam int CDEPTH = 2 * MAX_STREAM;

	logic [15:0]                   cur_mem [CDEPTH];
	logic                          bank_q;
	logic [1:0]                    pend_q;
	logic [rthd_pkg::LEN_W-1:0]    len_q;
	logic                          ovf_q;
	logic                          accept;
	logic                          room;
	logic [CAW-1:0]                wr_addr;

	always_comb begin
		unique case (item.mode)
			rthd_pkg::MODE_PAIR:  item_ready = !pend_q[bank_q];
			rthd_pkg::MODE_CLOSE: item_ready = !pend_q[bank_q] && !q_full;
			rthd_pkg::MODE_END:   item_ready = !q_full;
			default:              item_ready = 1'b1;
		endcase
	end

	assign accept  = item_valid && item_ready;
	assign room    = (len_q < rthd_pkg::LEN_W'(MAX_STREAM));
	assign wr_addr = CAW'(bank_q) * CAW'(MAX_STREAM) + CAW'(len_q);
	assign push    = accept && (item.mode == rthd_pkg::MODE_CLOSE ||
	                            item.mode == rthd_pkg::MODE_END);

	always_comb begin
		push_cmd.is_clear = (item.mode == rthd_pkg::MODE_END);
		push_cmd.bank     = bank_q;
		push_cmd.len      = len_q;
		push_cmd.trunc    = ovf_q;
		push_cmd.flags    = rthd_pkg::make_flags(item);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bank_q <= 1'b0;
			pend_q <= 2'b00;
			len_q  <= '0;
			ovf_q  <= 1'b0;
		end else begin
			if (done.done) begin
				pend_q[done.bank] <= 1'b0;
			end
			if (accept) begin
				unique case (item.mode)
					rthd_pkg::MODE_PAIR: begin
						if (room) begin
							len_q <= len_q + rthd_pkg::LEN_W'(1);
						end else begin
							ovf_q <= 1'b1;
						end
					end
					rthd_pkg::MODE_CLOSE: begin
						pend_q[bank_q] <= 1'b1;
						bank_q         <= ~bank_q;
						len_q          <= '0;
						ovf_q          <= 1'b0;
					end
					rthd_pkg::MODE_END: begin
						len_q <= '0;
						ovf_q <= 1'b0;
					end
					default: begin
					end
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept && item.mode == rthd_pkg::MODE_PAIR && room) begin
			cur_mem[wr_addr] <= {item.first_byte, item.second_byte};
		end
		rd_data <= cur_mem[rd_addr];
	end

endmodule

// ===== rtl/rthd_back.sv =====
module rthd_back #(
	parameter int MAX_STREAM = 16,
	parameter int CAW        = 5
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  rthd_pkg::cmd_t      q_head,
	output logic                pop,
	output rthd_pkg::done_t     done,
	output logic [CAW-1:0]      cur_addr,
	input  logic [15:0]         cur_data,
	output logic                res_valid,
	input  logic                res_ready,
	output rthd_pkg::res_t      res
);

	localparam int LW     = rthd_pkg::LEN_W;
	localparam int HDEPTH = rthd_pkg::HIST_DEPTH * MAX_STREAM;
	localparam int HAW    = $clog2(HDEPTH);

	typedef enum logic [4:0] {
		ST_IDLE, ST_PRE_RD, ST_PRE_CMP, ST_SUF_RD, ST_SUF_CMP, ST_NEXT, ST_CLAMP,
		ST_SEL, ST_CNT, ST_MID_RD, ST_MID_HI, ST_MID_LO, ST_FLG, ST_CPY_RD,
		ST_CPY_WR, ST_CLR0, ST_CLR1
	} state_t;

	state_t                         state_q;
	rthd_pkg::cmd_t                 cmd_q;
	logic [rthd_pkg::SLOT_W-1:0]    ent_q;
	logic [rthd_pkg::SLOT_W-1:0]    best_q;
	logic [rthd_pkg::SLOT_W-1:0]    head_q;
	logic [LW-1:0]                  tp_q, ts_q, pre_q, post_q, x_q;
	logic [LW-1:0]                  hlen_q [rthd_pkg::HIST_DEPTH];
	logic                           out_v_q;
	rthd_pkg::res_t                 out_q;
	logic [15:0]                    hist_mem [HDEPTH];
	logic [15:0]                    hist_data;

	logic [rthd_pkg::SLOT_W-1:0]    slot, new_slot;
	logic [LW-1:0]                  hl, len, lim, cur_idx, hist_idx, pc, sc, rest;
	logic [HAW-1:0]                 hist_addr, hist_waddr;
	logic                           can_emit, emit_en, emit_last;
	logic [7:0]                     emit_byte;
	logic                           better;

	assign len      = cmd_q.len;
	assign slot     = ent_q + head_q;
	assign new_slot = head_q - rthd_pkg::SLOT_W'(1);
	assign hl       = hlen_q[slot];
	assign lim      = (hl < len) ? hl : len;
	assign can_emit = !out_v_q || res_ready;
	assign better   = ({1'b0, tp_q} + {1'b0, ts_q}) > ({1'b0, pre_q} + {1'b0, post_q});

	always_comb begin
		unique case (state_q)
			ST_PRE_RD: begin
				cur_idx  = tp_q;
				hist_idx = tp_q;
			end
			ST_SUF_RD: begin
				cur_idx  = len - LW'(1) - ts_q;
				hist_idx = hl - LW'(1) - ts_q;
			end
			default: begin
				cur_idx  = x_q;
				hist_idx = x_q;
			end
		endcase
	end

	assign cur_addr   = CAW'(cmd_q.bank) * CAW'(MAX_STREAM) + CAW'(cur_idx);
	assign hist_addr  = HAW'(slot) * HAW'(MAX_STREAM) + HAW'(hist_idx);
	assign hist_waddr = HAW'(new_slot) * HAW'(MAX_STREAM) + HAW'(x_q);

	// Clamp both counts to seven, then keep the suffix inside what the prefix left.
	always_comb begin
		pc   = (pre_q > rthd_pkg::CLAMP_LIMIT) ? rthd_pkg::CLAMP_LIMIT : pre_q;
		sc   = (post_q > rthd_pkg::CLAMP_LIMIT) ? rthd_pkg::CLAMP_LIMIT : post_q;
		rest = len - pc;
		if (sc > rest) begin
			sc = rest;
		end
	end

	always_comb begin
		emit_en   = 1'b0;
		emit_last = 1'b0;
		emit_byte = 8'h00;
		unique case (state_q)
			ST_SEL: begin
				emit_en   = can_emit;
				emit_byte = {best_q, post_q[2:0], pre_q[2:0]};
			end
			ST_CNT: begin
				emit_en   = can_emit;
				emit_byte = 8'd1 + 8'(len) - 8'(pre_q) - 8'(post_q);
			end
			ST_MID_HI: begin
				emit_en   = can_emit;
				emit_byte = cur_data[15:8];
			end
			ST_MID_LO: begin
				emit_en   = can_emit;
				emit_byte = cur_data[7:0];
			end
			ST_FLG: begin
				emit_en   = can_emit;
				emit_last = 1'b1;
				emit_byte = cmd_q.flags;
			end
			ST_CLR0: begin
				emit_en = can_emit;
			end
			ST_CLR1: begin
				emit_en   = can_emit;
				emit_last = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign pop       = (state_q == ST_IDLE) && q_valid;
	assign done.done = (state_q == ST_CPY_RD) && !(x_q < len);
	assign done.bank = cmd_q.bank;
	assign res_valid = out_v_q;
	assign res       = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			out_v_q <= 1'b0;
			for (int i = 0; i < rthd_pkg::HIST_DEPTH; i++) begin
				hlen_q[i] <= '0;
			end
		end else begin
			if (emit_en) begin
				out_v_q           <= 1'b1;
				out_q.out_byte    <= emit_byte;
				out_q.last_of_run <= emit_last;
				out_q.truncated   <= cmd_q.is_clear ? 1'b0 : cmd_q.trunc;
			end else if (res_ready) begin
				out_v_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (q_valid) begin
						cmd_q  <= q_head;
						ent_q  <= '0;
						tp_q   <= '0;
						ts_q   <= '0;
						pre_q  <= '0;
						post_q <= '0;
						best_q <= '0;
						state_q <= q_head.is_clear ? ST_CLR0 : ST_PRE_RD;
					end
				end
				ST_PRE_RD: begin
					state_q <= (tp_q < lim) ? ST_PRE_CMP : ST_SUF_RD;
				end
				ST_PRE_CMP: begin
					if (hist_data == cur_data) begin
						tp_q    <= tp_q + LW'(1);
						state_q <= ST_PRE_RD;
					end else begin
						state_q <= ST_SUF_RD;
					end
				end
				ST_SUF_RD: begin
					state_q <= (ts_q < lim) ? ST_SUF_CMP : ST_NEXT;
				end
				ST_SUF_CMP: begin
					if (hist_data == cur_data) begin
						ts_q    <= ts_q + LW'(1);
						state_q <= ST_SUF_RD;
					end else begin
						state_q <= ST_NEXT;
					end
				end
				ST_NEXT: begin
					if (better) begin
						pre_q  <= tp_q;
						post_q <= ts_q;
						best_q <= ent_q;
					end
					tp_q <= '0;
					ts_q <= '0;
					if (ent_q == rthd_pkg::SLOT_W'(rthd_pkg::HIST_DEPTH - 1)) begin
						state_q <= ST_CLAMP;
					end else begin
						ent_q   <= ent_q + rthd_pkg::SLOT_W'(1);
						state_q <= ST_PRE_RD;
					end
				end
				ST_CLAMP: begin
					pre_q   <= pc;
					post_q  <= sc;
					state_q <= ST_SEL;
				end
				ST_SEL: begin
					if (can_emit) begin
						state_q <= ST_CNT;
					end
				end
				ST_CNT: begin
					if (can_emit) begin
						x_q     <= pre_q;
						state_q <= ST_MID_RD;
					end
				end
				ST_MID_RD: begin
					state_q <= (x_q < len - post_q) ? ST_MID_HI : ST_FLG;
				end
				ST_MID_HI: begin
					if (can_emit) begin
						state_q <= ST_MID_LO;
					end
				end
				ST_MID_LO: begin
					if (can_emit) begin
						x_q     <= x_q + LW'(1);
						state_q <= ST_MID_RD;
					end
				end
				ST_FLG: begin
					if (can_emit) begin
						x_q     <= '0;
						state_q <= ST_CPY_RD;
					end
				end
				ST_CPY_RD: begin
					if (x_q < len) begin
						state_q <= ST_CPY_WR;
					end else begin
						head_q           <= new_slot;
						hlen_q[new_slot] <= len;
						state_q          <= ST_IDLE;
					end
				end
				ST_CPY_WR: begin
					x_q     <= x_q + LW'(1);
					state_q <= ST_CPY_RD;
				end
				ST_CLR0: begin
					if (can_emit) begin
						state_q <= ST_CLR1;
					end
				end
				ST_CLR1: begin
					if (can_emit) begin
						for (int i = 0; i < rthd_pkg::HIST_DEPTH; i++) begin
							hlen_q[i] <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_CPY_WR) begin
			hist_mem[hist_waddr] <= cur_data;
		end
		hist_data <= hist_mem[hist_addr];
	end

	a_counts_fit: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEL) |-> (({1'b0, pre_q} + {1'b0, post_q}) <= {1'b0, len}))
		else $error("prefix plus suffix exceeds the stream length");

	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_NEXT) |-> (tp_q <= lim && ts_q <= lim))
		else $error("match scan ran past the shorter stream");

	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done.done |=> (state_q == ST_IDLE))
		else $error("bank released while the back part still works");

	a_last_then_copy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FLG && can_emit) |=> (state_q == ST_CPY_RD && x_q == '0))
		else $error("history push did not follow the flags byte");

endmodule

// ===== rtl/rule_table_history_delta_encoder.sv =====
// Channel  | Handshake                  | Payload
// item     | item_valid / item_ready    | item (rthd_pkg::item_t)
// res      | res_valid / res_ready      | res  (rthd_pkg::res_t)
//
// A pair element is stored in the front part, or marks overflow once the bank
// is full. A rule close, in the back part, reads and compares pairs against
// each of the four history entries, emits its bytes with one read per middle
// pair, and reads and writes each pair copied into the history; the registered
// reads of both stream memories call for the separate read states.
// An end-of-ruleset request emits two bytes. Reset clears the lengths, the
// request queue and the output register; the stream memories need no clearing.
// A stalled result holds the back part only; the front part keeps loading pairs
// into its second stream bank and queues its closing request in the two-entry queue.
module rule_table_history_delta_encoder #(
	parameter int MAX_STREAM = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             item_valid,
	output logic             item_ready,
	input  rthd_pkg::item_t  item,
	output logic             res_valid,
	input  logic             res_ready,
	output rthd_pkg::res_t   res
);

	// The stream buffer holds two banks of MAX_STREAM pairs each.
	localparam int CAW = $clog2(2 * MAX_STREAM);

	logic             push;
	rthd_pkg::cmd_t   push_cmd;
	logic             q_full;
	logic             pop;
	logic             q_valid;
	rthd_pkg::cmd_t   q_head;
	rthd_pkg::done_t  done;
	logic [CAW-1:0]   cur_addr;
	logic [15:0]      cur_data;

	// The front part loads pairs and turns each close or end of ruleset into a
	// request for the back part.
	rthd_front #(
		.MAX_STREAM (MAX_STREAM),
		.CAW        (CAW)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.push       (push),
		.push_cmd   (push_cmd),
		.q_full     (q_full),
		.done       (done),
		.rd_addr    (cur_addr),
		.rd_data    (cur_data)
	);

	// A two-entry queue lets the front part run ahead of the encoder.
	rthd_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_cmd   (push_cmd),
		.full       (q_full),
		.pop        (pop),
		.head_valid (q_valid),
		.head_cmd   (q_head)
	);

	// The back part matches against the history, emits bytes and updates the
	// history, or clears it at an end of ruleset.
	rthd_back #(
		.MAX_STREAM (MAX_STREAM),
		.CAW        (CAW)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_head     (q_head),
		.pop        (pop),
		.done       (done),
		.cur_addr   (cur_addr),
		.cur_data   (cur_data),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

endmodule

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps

// Self-checking bench for the rule table history delta encoder.
// Requests are driven on the item channel. A predictor runs the encoding on
// its own copy of the stream and history state and queues the bytes that each
// request should produce. The result channel is checked byte by byte against
// that queue.
module tb_top;

	localparam int STREAM_MAX  = 16;
	localparam int WATCH_LIMIT = 20000;
	localparam int HOLD_CYCLES = 400;
	localparam int TAIL_CYCLES = 600;
	localparam int ITEM_W      = $bits(rthd_pkg::item_t);

	// One row of the directed part. Rows with typed bytes are checked
	// against those bytes. All other rows are checked against the predictor.
	typedef struct {
		rthd_pkg::item_t it;
		int              ntyped;
		logic [7:0]      typed [3];
	} row_t;

	logic             clk;
	logic             arst_n;
	logic             item_valid;
	logic             item_ready;
	rthd_pkg::item_t  item;
	logic             res_valid;
	logic             res_ready;
	rthd_pkg::res_t   res;

	rule_table_history_delta_encoder dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.item       (item),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res        (res)
	);

	always begin
		clk = 1'b1;
		#2;
		clk = 1'b0;
		#2;
	end

	// These variables hold the predictor's copy of the block's state.
	logic [15:0] cur_pairs [STREAM_MAX];
	int          cur_len;
	bit          cur_ovf;
	logic [15:0] hist_pairs [rthd_pkg::HIST_DEPTH][STREAM_MAX];
	int          hist_len [rthd_pkg::HIST_DEPTH];

	rthd_pkg::res_t exp_bytes [$];
	int             row_of_req [$];
	row_t           rows [$];

	int errors;
	int tx_idle;
	int rx_idle;
	bit hold_req;
	int n_res;
	int n_rules;
	int n_trunc;
	int quiet;

	// The last four streams that the random part closes are kept here. Later rules
	// copy from these streams, so that the history search finds matches.
	logic [15:0] gen_pairs [rthd_pkg::HIST_DEPTH][STREAM_MAX + 4];
	int          gen_len [rthd_pkg::HIST_DEPTH];

	function automatic logic [7:0] flags_of(input rthd_pkg::item_t it);
		logic [7:0] f;
		f = 8'h00;
		if (it.prefix_kind == rthd_pkg::PK_OPSIZE) return 8'h80;
		if (it.prefix_kind == rthd_pkg::PK_ADSIZE) return 8'h81;
		if (it.prefix_kind == rthd_pkg::PK_REPNE)  return 8'h82;
		if (it.prefix_kind == rthd_pkg::PK_REP)    return 8'h83;
		if (it.is_call)      f |= 8'h01;
		if (it.is_cond_jump) f |= 8'h02;
		if (it.is_jump)      f |= 8'h04;
		if (it.is_ret)       f |= 8'h08;
		if (it.is_bad)       f |= 8'h10;
		if (it.has_imm8)     f |= 8'h20;
		if (it.has_imm16)    f |= 8'h40;
		if (it.has_imm32)    f |= 8'h60;
		return f;
	endfunction

	function automatic rthd_pkg::res_t mk_res(input logic [7:0] b, input bit last,
			input bit tr);
		rthd_pkg::res_t r;
		r.out_byte    = b;
		r.last_of_run = last;
		r.truncated   = tr;
		return r;
	endfunction

	// Updates the state for one request and appends the bytes it should emit.
	task automatic encode_request(input rthd_pkg::item_t it, ref rthd_pkg::res_t outq [$]);
		int pre;
		int post;
		int best;
		int tp;
		int ts;
		int lim;
		int hl;
		bit tr;
		if (it.mode == rthd_pkg::MODE_PAIR) begin
			if (cur_len < STREAM_MAX) begin
				cur_pairs[cur_len] = {it.first_byte, it.second_byte};
				cur_len++;
			end else begin
				cur_ovf = 1'b1;
			end
		end else if (it.mode == rthd_pkg::MODE_CLOSE) begin
			pre  = 0;
			post = 0;
			best = 0;
			tr   = cur_ovf;
			for (int i = 0; i < rthd_pkg::HIST_DEPTH; i++) begin
				hl  = hist_len[i];
				lim = (hl < cur_len) ? hl : cur_len;
				tp  = 0;
				ts  = 0;
				while (tp < lim && hist_pairs[i][tp] == cur_pairs[tp]) tp++;
				while (ts < lim && hist_pairs[i][hl-1-ts] == cur_pairs[cur_len-1-ts]) ts++;
				if (tp + ts > pre + post) begin
					pre  = tp;
					post = ts;
					best = i;
				end
			end
			if (pre > rthd_pkg::CLAMP_LIMIT) pre = rthd_pkg::CLAMP_LIMIT;
			if (post > rthd_pkg::CLAMP_LIMIT) post = rthd_pkg::CLAMP_LIMIT;
			if (post > cur_len - pre) post = cur_len - pre;
			outq.insert(outq.size(), mk_res(8'(best * 64 + post * 8 + pre), 1'b0, tr));
			outq.insert(outq.size(), mk_res(8'(1 + cur_len - pre - post), 1'b0, tr));
			for (int x = pre; x < cur_len - post; x++) begin
				outq.insert(outq.size(), mk_res(cur_pairs[x][15:8], 1'b0, tr));
				outq.insert(outq.size(), mk_res(cur_pairs[x][7:0], 1'b0, tr));
			end
			outq.insert(outq.size(), mk_res(flags_of(it), 1'b1, tr));
			// The newest stream goes to slot zero and the oldest one drops out.
			for (int i = rthd_pkg::HIST_DEPTH - 1; i > 0; i--) begin
				hist_pairs[i] = hist_pairs[i-1];
				hist_len[i]   = hist_len[i-1];
			end
			hist_pairs[0] = cur_pairs;
			hist_len[0]   = cur_len;
			cur_len = 0;
			cur_ovf = 1'b0;
			n_rules++;
			if (tr) n_trunc++;
		end else if (it.mode == rthd_pkg::MODE_END) begin
			outq.insert(outq.size(), mk_res(8'h00, 1'b0, 1'b0));
			outq.insert(outq.size(), mk_res(8'h00, 1'b1, 1'b0));
			for (int i = 0; i < rthd_pkg::HIST_DEPTH; i++) hist_len[i] = 0;
			cur_len = 0;
			cur_ovf = 1'b0;
		end
	endtask

	function automatic rthd_pkg::item_t mk_item(input rthd_pkg::mode_t m,
			input logic [7:0] a, input logic [7:0] b,
			input logic [2:0] pk, input logic [7:0] fl);
		rthd_pkg::item_t it;
		it.mode         = m;
		it.first_byte   = a;
		it.second_byte  = b;
		it.prefix_kind  = pk;
		it.is_call      = fl[0];
		it.is_cond_jump = fl[1];
		it.is_jump      = fl[2];
		it.is_ret       = fl[3];
		it.is_bad       = fl[4];
		it.has_imm8     = fl[5];
		it.has_imm16    = fl[6];
		it.has_imm32    = fl[7];
		return it;
	endfunction

	function automatic rthd_pkg::item_t rand_item(input rthd_pkg::mode_t m);
		rthd_pkg::item_t it;
		it      = rthd_pkg::item_t'(ITEM_W'({$urandom, $urandom}));
		it.mode = m;
		return it;
	endfunction

	task automatic add_row(input rthd_pkg::item_t it, input int n, input logic [7:0] b0,
			input logic [7:0] b1, input logic [7:0] b2);
		row_t r;
		r.it       = it;
		r.ntyped   = n;
		r.typed[0] = b0;
		r.typed[1] = b1;
		r.typed[2] = b2;
		rows.insert(rows.size(), r);
	endtask

	// Offers one request and waits for its handshake. Valid drops only on
	// the cycles that the sender idles, so it is never lowered and raised in
	// the same step.
	task automatic offer(input rthd_pkg::item_t it, input int row);
		while ($urandom_range(99) < tx_idle) begin
			item_valid <= 1'b0;
			@(posedge clk);
		end
		row_of_req.insert(row_of_req.size(), row);
		item_valid <= 1'b1;
		item       <= it;
		do @(posedge clk); while (!item_ready);
	endtask

	// Input side: each accepted request is run through the predictor. Where
	// the directed row has typed bytes, those bytes become the expectation.
	always @(posedge clk) begin
		rthd_pkg::res_t got [$];
		int             row;
		if (arst_n && item_valid && item_ready) begin
			got.delete();
			row = row_of_req.pop_front();
			encode_request(item, got);
			if (row >= 0 && rows[row].ntyped > 0) begin
				got.delete();
				for (int k = 0; k < rows[row].ntyped; k++)
					got.insert(got.size(), mk_res(rows[row].typed[k],
						k == rows[row].ntyped - 1, 1'b0));
			end
			foreach (got[k]) exp_bytes.insert(exp_bytes.size(), got[k]);
		end
	end

	// Output side: each accepted result is compared with the oldest expectation.
	always @(posedge clk) begin
		rthd_pkg::res_t e;
		if (arst_n && res_valid && res_ready) begin
			n_res++;
			if (exp_bytes.size() == 0) begin
				$error("unexpected result: out_byte %h", res.out_byte);
				errors++;
			end else begin
				e = exp_bytes.pop_front();
				if (res.out_byte !== e.out_byte) begin
					$error("out_byte: expected %h, actual %h", e.out_byte, res.out_byte);
					errors++;
				end
				if (res.last_of_run !== e.last_of_run) begin
					$error("last_of_run: expected %b, actual %b", e.last_of_run,
						res.last_of_run);
					errors++;
				end
				if (res.truncated !== e.truncated) begin
					$error("truncated: expected %b, actual %b", e.truncated, res.truncated);
					errors++;
				end
			end
		end
	end

	// Receiver. On request it holds ready low for a long stretch, so that the
	// block backs up and stops taking requests while the sender keeps offering.
	initial begin
		res_ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req) begin
				hold_req = 1'b0;
				res_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				res_ready <= ($urandom_range(99) >= rx_idle);
			end
		end
	end

	// The watchdog ends the run if no handshake happens on either channel
	// for too long.
	always @(posedge clk) begin
		if ((item_valid && item_ready) || (res_valid && res_ready)) begin
			quiet = 0;
		end else begin
			quiet++;
		end
		if (quiet >= WATCH_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	// Produces one random rule. Most rules are well formed, and many of them
	// copy from a recent stream, so that the history search finds long prefix
	// and suffix matches. Some rules are cut short by an end of ruleset.
	task automatic random_rule(ref int cnt);
		int          len;
		int          base;
		int          sel;
		logic [15:0] pr;
		logic [15:0] s [STREAM_MAX + 4];
		sel = $urandom_range(99);
		len = (sel < 8) ? 16 + $urandom_range(3) : $urandom_range(9);
		base = $urandom_range(rthd_pkg::HIST_DEPTH - 1);
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(99) < 65 && k < gen_len[base]) begin
				pr = gen_pairs[base][k];
			end else if ($urandom_range(99) < 50 && gen_len[base] > 0 &&
					len - k <= gen_len[base]) begin
				// The tail copies the tail of the base stream to form a suffix.
				pr = gen_pairs[base][gen_len[base] - (len - k)];
			end else if ($urandom_range(1)) begin
				pr = 16'($urandom);
			end else begin
				pr = {4'h0, 4'($urandom), 4'h0, 4'($urandom)};
			end
			s[k] = pr;
			offer(mk_item(rthd_pkg::MODE_PAIR, pr[15:8], pr[7:0], 3'd0, 8'h00), -1);
			cnt++;
		end
		sel = $urandom_range(99);
		if (sel < 6) begin
			offer(rand_item(rthd_pkg::MODE_END), -1);
		end else begin
			offer(rand_item(rthd_pkg::MODE_CLOSE), -1);
			for (int i = rthd_pkg::HIST_DEPTH - 1; i > 0; i--) begin
				gen_pairs[i] = gen_pairs[i-1];
				gen_len[i]   = gen_len[i-1];
			end
			gen_pairs[0] = s;
			gen_len[0]   = len;
		end
		cnt++;
		// The block ignores the unused mode. Such a request is noise and is
		// not counted toward the random part.
		if ($urandom_range(99) < 5) offer(rand_item(rthd_pkg::MODE_NONE), -1);
	endtask

	initial begin
		int cnt;
		arst_n     = 1'b0;
		item_valid = 1'b0;
		item       = '0;
		hold_req   = 1'b0;
		errors     = 0;
		n_res      = 0;
		n_rules    = 0;
		n_trunc    = 0;
		quiet      = 0;
		cur_len    = 0;
		cur_ovf    = 1'b0;
		for (int i = 0; i < rthd_pkg::HIST_DEPTH; i++) begin
			hist_len[i] = 0;
			gen_len[i]  = 0;
		end
		tx_idle = 9;
		rx_idle = 61;

		// Directed part. An empty rule against an empty history encodes to
		// slot zero, a count of one and the flags byte alone.
		add_row(mk_item(rthd_pkg::MODE_CLOSE, 8'h00, 8'h00, rthd_pkg::PK_OPSIZE, 8'h00),
			3, 8'h00, 8'h01, 8'h80);
		add_row(mk_item(rthd_pkg::MODE_CLOSE, 8'h00, 8'h00, 3'd0, 8'hFF),
			3, 8'h00, 8'h01, 8'h7F);
		add_row(mk_item(rthd_pkg::MODE_END, 8'h00, 8'h00, 3'd0, 8'h00),
			2, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_PAIR, 8'h00, 8'h00, 3'd0, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_PAIR, 8'hFF, 8'hFF, 3'd0, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_CLOSE, 8'h00, 8'h00, rthd_pkg::PK_ADSIZE, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		// The same stream again matches its predecessor completely.
		add_row(mk_item(rthd_pkg::MODE_PAIR, 8'h00, 8'h00, 3'd0, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_PAIR, 8'hFF, 8'hFF, 3'd0, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_CLOSE, 8'h00, 8'h00, rthd_pkg::PK_REPNE, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_NONE, 8'hA5, 8'h5A, 3'd7, 8'hFF),
			0, 8'h00, 8'h00, 8'h00);
		// A stream one pair longer than the bound is truncated.
		for (int k = 0; k <= STREAM_MAX; k++)
			add_row(mk_item(rthd_pkg::MODE_PAIR, 8'(k), 8'(8'hF0 - k), 3'd0, 8'h00),
				0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_CLOSE, 8'h00, 8'h00, rthd_pkg::PK_REP, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		// An end of ruleset mid-rule discards the loaded pair, so the close
		// that follows sees an empty stream and an empty history.
		add_row(mk_item(rthd_pkg::MODE_PAIR, 8'h12, 8'h34, 3'd0, 8'h00),
			0, 8'h00, 8'h00, 8'h00);
		add_row(mk_item(rthd_pkg::MODE_END, 8'h00, 8'h00, 3'd0, 8'h00),
			2, 8'h00, 8'h00, 8'h00);
		// An unknown prefix kind acts as no prefix.
		add_row(mk_item(rthd_pkg::MODE_CLOSE, 8'h00, 8'h00, 3'd5, 8'h01),
			3, 8'h00, 8'h01, 8'h01);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (rows[r]) offer(rows[r].it, r);

		// Random part in three idling phases. The last phase starts with a
		// long receiver hold-off.
		cnt = 0;
		while (cnt < 100) begin
			if (cnt >= 33 && tx_idle == 9) begin
				tx_idle = 61;
				rx_idle = 9;
			end else if (cnt >= 66 && tx_idle == 61) begin
				tx_idle  = 0;
				rx_idle  = 0;
				hold_req = 1'b1;
			end
			random_rule(cnt);
		end
		item_valid <= 1'b0;

		while (exp_bytes.size() != 0) @(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);
		if (exp_bytes.size() != 0) begin
			$error("expected results left over: %0d", exp_bytes.size());
			errors++;
		end

		$display("Run covered %0d rules (%0d truncated) and %0d result bytes,",
			n_rules, n_trunc, n_res);
		$display("with history matches, stream overflow and end-of-ruleset cases.");
		if (errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule

// ===== files.f =====
rtl/rthd_pkg.sv
rtl/rthd_queue.sv
rtl/rthd_front.sv
rtl/rthd_back.sv
rtl/rule_table_history_delta_encoder.sv
sim/tb_top.sv
